[hdl/cbor_token_stream_parser_assert.svh]
// Assertion macros used by the CBOR token stream parser RTL.
`ifndef CBOR_TOKEN_STREAM_PARSER_ASSERT_SVH
`define CBOR_TOKEN_STREAM_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CBTSP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define CBTSP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CBTSP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define CBTSP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hdl/cbortsp_pkg.sv]
// Types and constants of the CBOR token stream parser.
package cbortsp_pkg;

    localparam int CBTSP_QUEUE_DEPTH = 4;

    // Parser phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ARG  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;

    // Major types used by name
    localparam logic [2:0] MAJ_BYTES  = 3'd2;
    localparam logic [2:0] MAJ_TEXT   = 3'd3;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    // Minor codes
    localparam logic [4:0] MN_FALSE = 5'd20;
    localparam logic [4:0] MN_TRUE  = 5'd21;
    localparam logic [4:0] MN_NULL  = 5'd22;
    localparam logic [4:0] MN_UNDEF = 5'd23;
    localparam logic [4:0] MN_ARG1  = 5'd24;
    localparam logic [4:0] MN_ARG8  = 5'd27;
    localparam logic [4:0] MN_F32   = 5'd26;
    localparam logic [4:0] MN_F64   = 5'd27;

    // Token types
    localparam logic [3:0] TT_SPECIAL = 4'd7;
    localparam logic [3:0] TT_BOOL    = 4'd8;
    localparam logic [3:0] TT_NULL    = 4'd9;
    localparam logic [3:0] TT_UNDEF   = 4'd10;
    localparam logic [3:0] TT_FLOAT   = 4'd11;
    localparam logic [3:0] TT_END     = 4'd12;
    localparam logic [3:0] TT_ERROR   = 4'd13;
    localparam logic [3:0] TT_PAYLOAD = 4'd14;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_WIDTH     = 2'd1;
    localparam logic [1:0] ERR_SHORT     = 2'd2;
    localparam logic [1:0] ERR_NO_INT64  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_buffer;
        logic       last_of_buffer;
    } t_item;

    typedef struct packed {
        logic [3:0]  token_type;
        logic [63:0] argument;
        logic        float_is_double;
        logic [1:0]  error_code;
        logic [7:0]  payload_byte;
        logic        payload_last;
    } t_result;

    // Up to two results written to the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    d0;
        t_result    d1;
    } t_push;

endpackage

[hdl/cbor_token_stream_parser.sv]
// Top level of the CBOR token stream parser.
//
//  channel   direction  handshake                payload
//  input     in         i_in_valid / o_in_stall  i_in_data  (t_item)
//  output    out        o_out_valid / i_out_stall o_out_data (t_result)
//  config    in         i_cfg_we                 i_cfg_wdata (int64_enable)
//
// One byte is accepted per cycle while the input is not stalled. A byte is
// held in the input register, is decoded, and its zero, one or two results go
// into the result queue in the same cycle; results reach the output from the
// queue. The queue delivers one result per cycle while the output is not
// stalled, so bytes that yield two results (end or error on the last byte)
// are bounded by the output port. The input stalls only while a byte is held
// and the queue lacks room for two. Reset is synchronous; int64_enable returns
// to 1 and the parser goes idle.
module cbor_token_stream_parser
    import cbortsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = CBTSP_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_item   i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_data,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata
);

    `include "cbor_token_stream_parser_assert.svh"

    // Build the token for a complete initial byte plus argument.
    function automatic t_result f_finish(input logic [2:0] mj, input logic [4:0] mn,
                                         input logic [63:0] arg);
        t_result r;
        r = '0;
        if (mj == MAJ_SIMPLE) begin
            case (mn) inside
                MN_FALSE, MN_TRUE: begin
                    r.token_type = TT_BOOL;
                    r.argument   = {63'd0, mn == MN_TRUE};
                end
                MN_NULL:  r.token_type = TT_NULL;
                MN_UNDEF: r.token_type = TT_UNDEF;
                MN_F32, MN_F64: begin
                    r.token_type      = TT_FLOAT;
                    r.argument        = arg;
                    r.float_is_double = (mn == MN_F64);
                end
                default: begin
                    r.token_type = TT_SPECIAL;
                    r.argument   = arg;
                end
            endcase
        end else begin
            // integers, strings headers, arrays, maps and tags keep their major
            r.token_type = {1'b0, mj};
            r.argument   = arg;
        end
        return r;
    endfunction

    // Input register
    logic   r_in_valid;
    t_item  r_in;

    // Parser state
    logic [1:0]  r_phase,    n_phase;
    logic [2:0]  r_major,    n_major;
    logic [4:0]  r_minor,    n_minor;
    logic [3:0]  r_arg_left, n_arg_left;
    logic [63:0] r_acc,      n_acc;
    logic [63:0] r_pay_left, n_pay_left;
    logic        r_err,      n_err;
    logic        r_int64;

    logic        q_room;
    logic        proc_go;
    t_push       q_push;

    t_result     res_a, res_b;
    logic        res_a_v, res_b_v;
    logic        fin;
    logic [63:0] fin_arg;
    logic [63:0] acc_shift;
    logic [3:0]  arg_dec;
    logic [63:0] pay_dec;
    logic [7:0]  b;

    assign proc_go    = r_in_valid && q_room;
    assign o_in_stall = r_in_valid && !q_room;

    assign b         = r_in.data_byte;
    assign acc_shift = {r_acc[55:0], b};
    assign arg_dec   = r_arg_left - 4'd1;
    assign pay_dec   = r_pay_left - 64'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Decode of the held byte
    always_comb begin
        n_phase    = r_phase;
        n_major    = r_major;
        n_minor    = r_minor;
        n_arg_left = r_arg_left;
        n_acc      = r_acc;
        n_pay_left = r_pay_left;
        n_err      = r_err;
        res_a      = '0;
        res_a_v    = 1'b0;
        res_b      = '0;
        res_b_v    = 1'b0;
        fin        = 1'b0;
        fin_arg    = '0;

        if (proc_go) begin
            if (r_in.first_of_buffer) begin
                n_err      = 1'b0;
                n_phase    = PH_IDLE;
                n_arg_left = '0;
                n_acc      = '0;
                n_pay_left = '0;
            end

            if (!n_err) begin
                unique case (n_phase)
                    PH_ARG: begin
                        n_acc      = acc_shift;
                        n_arg_left = arg_dec;
                        if (arg_dec == 4'd0) begin
                            fin     = 1'b1;
                            fin_arg = acc_shift;
                        end
                    end
                    PH_PAY: begin
                        n_pay_left           = pay_dec;
                        res_a_v              = 1'b1;
                        res_a.token_type     = TT_PAYLOAD;
                        res_a.payload_byte   = b;
                        res_a.payload_last   = (pay_dec == 64'd0);
                        if (pay_dec == 64'd0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        // initial byte
                        n_major = b[7:5];
                        n_minor = b[4:0];
                        n_acc   = '0;
                        if (b[4:0] < MN_ARG1) begin
                            fin     = 1'b1;
                            fin_arg = {59'd0, b[4:0]};
                        end else if (b[4:0] > MN_ARG8) begin
                            res_a_v          = 1'b1;
                            res_a.token_type = TT_ERROR;
                            res_a.error_code = ERR_WIDTH;
                            n_err            = 1'b1;
                            n_phase          = PH_IDLE;
                        end else if (b[4:0] == MN_ARG8 && !r_int64 &&
                                     b[7:5] != MAJ_SIMPLE) begin
                            res_a_v          = 1'b1;
                            res_a.token_type = TT_ERROR;
                            res_a.error_code = ERR_NO_INT64;
                            n_err            = 1'b1;
                            n_phase          = PH_IDLE;
                        end else begin
                            n_arg_left = 4'd1 << b[1:0];
                            n_phase    = PH_ARG;
                        end
                    end
                endcase

                if (fin) begin
                    res_a_v = 1'b1;
                    res_a   = f_finish(n_major, n_minor, fin_arg);
                    n_phase = PH_IDLE;
                    // non-empty string: payload bytes follow
                    if ((n_major == MAJ_BYTES || n_major == MAJ_TEXT) &&
                        fin_arg != 64'd0) begin
                        n_pay_left = fin_arg;
                        n_phase    = PH_PAY;
                    end
                end

                if (r_in.last_of_buffer && !n_err) begin
                    res_b_v = 1'b1;
                    if (n_phase == PH_ARG || n_phase == PH_PAY) begin
                        res_b.token_type = TT_ERROR;
                        res_b.error_code = ERR_SHORT;
                        n_err            = 1'b1;
                        n_phase          = PH_IDLE;
                    end else begin
                        res_b.token_type = TT_END;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_err   <= 1'b0;
            r_int64 <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_err   <= n_err;
            if (i_cfg_we) begin
                r_int64 <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_major    <= n_major;
        r_minor    <= n_minor;
        r_arg_left <= n_arg_left;
        r_acc      <= n_acc;
        r_pay_left <= n_pay_left;
    end

    // Compact the two result slots into queue writes
    always_comb begin
        q_push.cnt = {1'b0, res_a_v} + {1'b0, res_b_v};
        q_push.d0  = res_a_v ? res_a : res_b;
        q_push.d1  = res_b;
    end

    cbortsp_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_room  (q_room),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    `CBTSP_ASSERT_IMPLIES(a_push_needs_room, i_clk, i_rst_n,
        q_push.cnt != 2'd0, q_room, "queue write without room")
    `CBTSP_ASSERT_IMPLIES(a_err_silent, i_clk, i_rst_n,
        proc_go && r_err && !r_in.first_of_buffer, q_push.cnt == 2'd0,
        "result while error latched")
    `CBTSP_ASSERT_IMPLIES(a_last_reports, i_clk, i_rst_n,
        proc_go && r_in.last_of_buffer && (!r_err || r_in.first_of_buffer),
        q_push.cnt != 2'd0, "last byte gave no end or error")
    `CBTSP_ASSERT_IMPLIES(a_arg_count, i_clk, i_rst_n,
        r_phase == PH_ARG, r_arg_left != 4'd0, "argument phase with no bytes left")

endmodule

[hdl/cbortsp_result_queue.sv]
// Result queue: takes up to two results a cycle, delivers one per transaction.
module cbortsp_result_queue
    import cbortsp_pkg::*;
#(
    parameter int DEPTH = CBTSP_QUEUE_DEPTH  // power of two, at least 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_stall
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_head;
    logic [AW-1:0]   r_tail;
    logic [CW-1:0]   r_count;
    logic            pop;
    logic [AW-1:0]   tail_p1;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign pop     = o_valid && !i_stall;
    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign tail_p1 = r_tail + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (pop) begin
                r_head <= r_head + AW'(1);
            end
            r_tail  <= r_tail + AW'(i_push.cnt);
            r_count <= r_count + CW'(i_push.cnt) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_tail] <= i_push.d0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[tail_p1] <= i_push.d1;
        end
    end

endmodule
